// ===== hw/rtl/crcgc_pkg.sv =====
package crcgc_pkg;

  localparam int unsigned MaxDegreeDefault = 32;
  localparam int unsigned PolyW            = 32;
  localparam int unsigned DegW             = 6;
  localparam int unsigned RemOutW          = 32;
  localparam int unsigned CfgIdxW          = 2;
  localparam int unsigned CfgDataW         = 32;
  localparam int unsigned QueueDepth       = 2;

  localparam logic [PolyW-1:0] PolyReset  = 32'd7;
  localparam logic [DegW-1:0]  DegReset   = 6'd3;
  localparam logic             CheckReset = 1'b0;

  typedef enum logic [CfgIdxW-1:0] {
    REG_POLY_TERMS = 2'd0,
    REG_DEGREE     = 2'd1,
    REG_CHECK_MODE = 2'd2
  } cfg_reg_e;

  // One classified bit handed from the front to the back
  typedef struct packed {
    logic data_bit;
    logic eom;
    logic check;
  } job_t;

endpackage

// ===== hw/rtl/crcgc_if.sv =====
interface crcgc_in_if;
  logic valid;
  logic ready;
  logic data_bit;
  logic end_of_message;

  modport source (output valid, output data_bit, output end_of_message, input ready);
  modport sink   (input valid, input data_bit, input end_of_message, output ready);
endinterface

interface crcgc_out_if;
  import crcgc_pkg::*;
  logic               valid;
  logic               ready;
  logic               code_bit;
  logic               is_last;
  logic [RemOutW-1:0] remainder;
  logic               crc_error;

  modport source (output valid, output code_bit, output is_last, output remainder,
                  output crc_error, input ready);
  modport sink   (input valid, input code_bit, input is_last, input remainder,
                  input crc_error, output ready);
endinterface

// ===== hw/rtl/crcgc_queue.sv =====
module crcgc_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CW'(1);
    end else if (!push_i && pop_i) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ===== hw/rtl/crcgc_front.sv =====
module crcgc_front #(
  parameter int unsigned MAX_DEGREE = crcgc_pkg::MaxDegreeDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [crcgc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [crcgc_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  input  logic                           in_data_bit_i,
  input  logic                           in_eom_i,
  output logic                           in_ready_o,
  input  logic                           full_i,
  output logic                           push_o,
  output crcgc_pkg::job_t                job_o,
  output logic [MAX_DEGREE-1:0]          rem_o,
  output logic [$clog2(MAX_DEGREE+1)-1:0] deg_o
);
  import crcgc_pkg::*;

  localparam int unsigned DW   = $clog2(MAX_DEGREE + 1);
  localparam int unsigned IW   = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam int unsigned CMPW = (DW > DegW) ? DW : DegW;
  localparam int unsigned PW   = (MAX_DEGREE > PolyW) ? MAX_DEGREE : PolyW;

  logic [PolyW-1:0]      poly_q;
  logic [DegW-1:0]       deg_q;
  logic                  check_q;
  logic [MAX_DEGREE-1:0] rem_q, rem_d;

  logic [CMPW-1:0]       deg_cmp;
  logic [DW-1:0]         eff_deg;
  logic [MAX_DEGREE-1:0] mask;
  logic [PW-1:0]         poly_x;
  logic [MAX_DEGREE-1:0] poly_m;
  logic [MAX_DEGREE-1:0] rem_m;
  logic                  top;
  logic [MAX_DEGREE-1:0] rem_next;
  logic                  accept;

  // Clamp the degree register into 1..MAX_DEGREE
  always_comb begin
    deg_cmp = CMPW'(deg_q);
    if (deg_cmp == '0) begin
      eff_deg = DW'(1);
    end else if (deg_cmp > CMPW'(MAX_DEGREE)) begin
      eff_deg = DW'(MAX_DEGREE);
    end else begin
      eff_deg = DW'(deg_cmp);
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_DEGREE; i++) begin
      mask[i] = (DW'(i) < eff_deg);
    end
  end

  assign poly_x = PW'(poly_q);
  assign poly_m = poly_x[MAX_DEGREE-1:0] & mask;
  assign rem_m  = rem_q & mask;
  assign top    = rem_m[IW'(eff_deg - DW'(1))];

  always_comb begin
    if (check_q) begin
      rem_next = ((rem_m << 1) | MAX_DEGREE'(in_data_bit_i)) & mask;
      if (top) begin
        rem_next = rem_next ^ poly_m;
      end
    end else begin
      rem_next = (rem_m << 1) & mask;
      if (top ^ in_data_bit_i) begin
        rem_next = rem_next ^ poly_m;
      end
    end
  end

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  // Check mode drops every bit but the last
  assign push_o     = accept && (!check_q || in_eom_i);

  assign job_o.data_bit = in_data_bit_i;
  assign job_o.eom      = in_eom_i;
  assign job_o.check    = check_q;
  assign rem_o          = rem_next;
  assign deg_o          = eff_deg;

  always_comb begin
    rem_d = rem_q;
    if (accept) begin
      rem_d = in_eom_i ? '0 : rem_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q  <= PolyReset;
      deg_q   <= DegReset;
      check_q <= CheckReset;
      rem_q   <= '0;
    end else begin
      rem_q <= rem_d;
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_idx_i))
          REG_POLY_TERMS: poly_q  <= cfg_data_i[PolyW-1:0];
          REG_DEGREE:     deg_q   <= cfg_data_i[DegW-1:0];
          REG_CHECK_MODE: check_q <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== hw/rtl/crcgc_back.sv =====
module crcgc_back #(
  parameter int unsigned MAX_DEGREE = crcgc_pkg::MaxDegreeDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            job_valid_i,
  input  crcgc_pkg::job_t                 job_i,
  input  logic [MAX_DEGREE-1:0]           rem_i,
  input  logic [$clog2(MAX_DEGREE+1)-1:0] deg_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            code_bit_o,
  output logic                            is_last_o,
  output logic [crcgc_pkg::RemOutW-1:0]   remainder_o,
  output logic                            crc_error_o
);
  import crcgc_pkg::*;

  localparam int unsigned DW = $clog2(MAX_DEGREE + 1);
  localparam int unsigned IW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam int unsigned XW = (MAX_DEGREE > RemOutW) ? MAX_DEGREE : RemOutW;

  logic                  valid_q, valid_d;
  logic                  tail_q, tail_d;
  logic [IW-1:0]         idx_q, idx_d;
  logic [MAX_DEGREE-1:0] tail_rem_q, tail_rem_d;
  logic                  cb_q, cb_d;
  logic                  last_q, last_d;
  logic [RemOutW-1:0]    rem_out_q, rem_out_d;
  logic                  err_q, err_d;

  logic                  load;
  logic [XW-1:0]         job_rem_x;
  logic [XW-1:0]         tail_rem_x;

  assign job_rem_x  = XW'(rem_i);
  assign tail_rem_x = XW'(tail_rem_q);

  assign load  = !valid_q || out_ready_i;
  assign pop_o = load && !tail_q && job_valid_i;

  always_comb begin
    valid_d    = valid_q;
    tail_d     = tail_q;
    idx_d      = idx_q;
    tail_rem_d = tail_rem_q;
    cb_d       = cb_q;
    last_d     = last_q;
    rem_out_d  = rem_out_q;
    err_d      = err_q;
    if (load) begin
      if (tail_q) begin
        // Shift out the appended remainder, most significant first
        valid_d   = 1'b1;
        cb_d      = tail_rem_q[idx_q];
        last_d    = (idx_q == '0);
        rem_out_d = (idx_q == '0) ? tail_rem_x[RemOutW-1:0] : '0;
        err_d     = 1'b0;
        if (idx_q == '0) begin
          tail_d = 1'b0;
        end else begin
          idx_d = idx_q - IW'(1);
        end
      end else if (job_valid_i) begin
        valid_d = 1'b1;
        if (job_i.check) begin
          cb_d      = 1'b0;
          last_d    = 1'b1;
          rem_out_d = job_rem_x[RemOutW-1:0];
          err_d     = |rem_i;
        end else begin
          cb_d      = job_i.data_bit;
          last_d    = 1'b0;
          rem_out_d = '0;
          err_d     = 1'b0;
          if (job_i.eom) begin
            tail_d     = 1'b1;
            idx_d      = IW'(deg_i - DW'(1));
            tail_rem_d = rem_i;
          end
        end
      end else begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tail_q  <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      tail_q  <= tail_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tail_rem_q <= tail_rem_d;
    cb_q       <= cb_d;
    last_q     <= last_d;
    rem_out_q  <= rem_out_d;
    err_q      <= err_d;
  end

  assign out_valid_o = valid_q;
  assign code_bit_o  = cb_q;
  assign is_last_o   = last_q;
  assign remainder_o = rem_out_q;
  assign crc_error_o = err_q;

endmodule

// ===== hw/rtl/crc_generate_check_serial.sv =====
// Bit-serial CRC generator and checker with a configurable generator polynomial.
// Input channel in_i: one message bit per transaction, most significant first,
// with end_of_message on the final bit. Output channel out_o: code_bit, is_last,
// remainder and crc_error per result transaction.
// Generate mode echoes every bit; after the last bit it appends degree remainder
// bits, the final one marked is_last and carrying the remainder. Check mode gives
// one result per codeword, on its last bit: remainder and crc_error.
// Configuration (poly_terms, degree, check_mode) is written through cfg_we_i,
// cfg_idx_i, cfg_data_i; the user must do so only while the block is idle, since
// the block itself does not enforce it. An accepted bit passes through the queue
// and then the output register before its result is presented.
// Throughput: one bit per cycle while in_i.ready is high, set by the single XOR
// step of the running remainder in the front end. In generate mode a message end
// occupies the output while its degree remainder bits are appended, during which
// the two-entry queue fills and in_i.ready drops.
// Reset clears the running remainder, empties the queue and the output register,
// and loads poly_terms 7, degree 3, generate mode.
// When the receiver stalls, the output register holds its result; the queue
// keeps absorbing bits until full, then in_i.ready goes low.
module crc_generate_check_serial #(
  parameter int unsigned MAX_DEGREE = crcgc_pkg::MaxDegreeDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [crcgc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [crcgc_pkg::CfgDataW-1:0] cfg_data_i,
  crcgc_in_if.sink                       in_i,
  crcgc_out_if.source                    out_o
);
  import crcgc_pkg::*;

  localparam int unsigned DW = $clog2(MAX_DEGREE + 1);
  localparam int unsigned QW = $bits(job_t) + MAX_DEGREE + DW;

  logic                  push;
  logic                  pop;
  logic                  full;
  logic                  empty;
  job_t                  job_in, job_out;
  logic [MAX_DEGREE-1:0] rem_in, rem_out;
  logic [DW-1:0]         deg_in, deg_out;
  logic [QW-1:0]         q_wdata, q_rdata;

  crcgc_front #(
    .MAX_DEGREE (MAX_DEGREE)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_i.valid),
    .in_data_bit_i (in_i.data_bit),
    .in_eom_i      (in_i.end_of_message),
    .in_ready_o    (in_i.ready),
    .full_i        (full),
    .push_o        (push),
    .job_o         (job_in),
    .rem_o         (rem_in),
    .deg_o         (deg_in)
  );

  assign q_wdata = {job_in, rem_in, deg_in};
  assign {job_out, rem_out, deg_out} = q_rdata;

  crcgc_queue #(
    .WIDTH (QW),
    .DEPTH (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (q_wdata),
    .pop_i   (pop),
    .rdata_o (q_rdata),
    .full_o  (full),
    .empty_o (empty)
  );

  crcgc_back #(
    .MAX_DEGREE (MAX_DEGREE)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (!empty),
    .job_i       (job_out),
    .rem_i       (rem_out),
    .deg_i       (deg_out),
    .pop_o       (pop),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .code_bit_o  (out_o.code_bit),
    .is_last_o   (out_o.is_last),
    .remainder_o (out_o.remainder),
    .crc_error_o (out_o.crc_error)
  );

endmodule

// ===== dv/crcgc_checker.sv =====
module crcgc_checker #(
  parameter int unsigned MAX_DEGREE = crcgc_pkg::MaxDegreeDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [crcgc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [crcgc_pkg::CfgDataW-1:0] cfg_data_i,
  crcgc_in_if                            in_mon,
  crcgc_out_if                           out_mon,
  output int unsigned                    fail_cnt_o,
  output int unsigned                    pending_o,
  output int unsigned                    result_cnt_o
);
  import crcgc_pkg::*;

  typedef struct packed {
    logic               code_bit;
    logic               is_last;
    logic [RemOutW-1:0] remainder;
    logic               crc_error;
  } crc_result_t;

  crc_result_t        expected_results[$];
  logic [PolyW-1:0]   poly_terms  = PolyReset;
  logic [DegW-1:0]    degree      = DegReset;
  logic               check_mode  = CheckReset;
  logic [63:0]        crc_acc     = '0;
  int unsigned        fails       = 0;
  int unsigned        results     = 0;

  function automatic int unsigned active_degree(logic [DegW-1:0] d);
    if (d == 0) return 1;
    if (d > MAX_DEGREE) return MAX_DEGREE;
    return d;
  endfunction

  // Advance the running remainder by one accepted bit and queue what it produces.
  function automatic void divide_bit(logic b, logic eom);
    int unsigned d;
    logic [63:0] mask;
    logic [63:0] poly;
    logic [63:0] r;
    logic        msb;
    crc_result_t res;
    d    = active_degree(degree);
    mask = (64'd1 << d) - 64'd1;
    poly = {32'd0, poly_terms} & mask;
    r    = crc_acc & mask;
    msb  = r[d-1];
    if (check_mode) begin
      r = ((r << 1) | {63'd0, b}) & mask;
      if (msb) r = r ^ poly;
      if (eom) begin
        res.code_bit  = 1'b0;
        res.is_last   = 1'b1;
        res.remainder = r[RemOutW-1:0];
        res.crc_error = (r != 0);
        expected_results.push_back(res);
        r = '0;
      end
    end else begin
      r = (r << 1) & mask;
      if (msb ^ b) r = r ^ poly;
      res = '0;
      res.code_bit = b;
      expected_results.push_back(res);
      if (eom) begin
        for (int unsigned i = 0; i < d; i++) begin
          res.code_bit  = r[d-1-i];
          res.is_last   = (i == d - 1);
          res.remainder = (i == d - 1) ? r[RemOutW-1:0] : '0;
          res.crc_error = 1'b0;
          expected_results.push_back(res);
        end
        r = '0;
      end
    end
    crc_acc = r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    crc_result_t exp_res;
    if (!rst_ni) begin
      expected_results.delete();
      poly_terms   = PolyReset;
      degree       = DegReset;
      check_mode   = CheckReset;
      crc_acc      = '0;
      pending_o    <= 0;
      fail_cnt_o   <= fails;
      result_cnt_o <= results;
    end else begin
      // A bit accepted at this edge still sees the old register values
      if (in_mon.valid && in_mon.ready) divide_bit(in_mon.data_bit, in_mon.end_of_message);
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_POLY_TERMS: poly_terms = cfg_data_i[PolyW-1:0];
          REG_DEGREE:     degree     = cfg_data_i[DegW-1:0];
          REG_CHECK_MODE: check_mode = cfg_data_i[0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        results++;
        if (expected_results.size() == 0) begin
          $error("unexpected result transaction: code_bit %0d is_last %0d remainder %h",
                 out_mon.code_bit, out_mon.is_last, out_mon.remainder);
          fails++;
        end else begin
          exp_res = expected_results.pop_front();
          if (out_mon.code_bit !== exp_res.code_bit) begin
            $error("code_bit: expected %0d, got %0d", exp_res.code_bit, out_mon.code_bit);
            fails++;
          end
          if (out_mon.is_last !== exp_res.is_last) begin
            $error("is_last: expected %0d, got %0d", exp_res.is_last, out_mon.is_last);
            fails++;
          end
          if (out_mon.remainder !== exp_res.remainder) begin
            $error("remainder: expected %h, got %h", exp_res.remainder, out_mon.remainder);
            fails++;
          end
          if (out_mon.crc_error !== exp_res.crc_error) begin
            $error("crc_error: expected %0d, got %0d", exp_res.crc_error, out_mon.crc_error);
            fails++;
          end
        end
      end
      pending_o    <= expected_results.size();
      fail_cnt_o   <= fails;
      result_cnt_o <= results;
    end
  end

endmodule

// ===== dv/crc_generate_check_serial_tb.sv =====
module crc_generate_check_serial_tb;
  import crcgc_pkg::*;

  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned TotalBits  = 400;

  logic                clk_i      = 1'b0;
  logic                rst_ni     = 1'b0;
  logic                cfg_we     = 1'b0;
  cfg_reg_e            cfg_idx    = REG_POLY_TERMS;
  logic [CfgDataW-1:0] cfg_data   = '0;
  logic                src_valid  = 1'b0;
  logic                src_bit    = 1'b0;
  logic                src_eom    = 1'b0;
  logic                sink_ready = 1'b0;
  logic                no_idle    = 1'b0;

  int unsigned fail_cnt;
  int unsigned pending_cnt;
  int unsigned result_cnt;
  int unsigned bits_sent    = 0;
  int unsigned msgs_sent    = 0;
  int unsigned settings_cnt = 0;
  int unsigned quiet_cycles = 0;
  int unsigned stall_left   = 0;

  logic [PolyW-1:0] cur_poly = PolyReset;
  logic [DegW-1:0]  cur_deg  = DegReset;

  crcgc_in_if  in_if ();
  crcgc_out_if out_if ();

  assign in_if.valid          = src_valid;
  assign in_if.data_bit       = src_bit;
  assign in_if.end_of_message = src_eom;
  assign out_if.ready         = sink_ready;

  crc_generate_check_serial dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  crcgc_checker u_checker (
    .clk_i,
    .rst_ni,
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_mon       (in_if),
    .out_mon      (out_if),
    .fail_cnt_o   (fail_cnt),
    .pending_o    (pending_cnt),
    .result_cnt_o (result_cnt)
  );

  always #10 clk_i = ~clk_i;

  function automatic int unsigned pick_gap();
    int unsigned sel;
    if (no_idle) return 0;
    sel = $urandom_range(0, 99);
    if (sel < 70) return 0;
    if (sel < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int unsigned eff_deg(logic [DegW-1:0] d);
    if (d == 0) return 1;
    if (d > MaxDegreeDefault) return MaxDegreeDefault;
    return d;
  endfunction

  // Receiver: stall at random, hold ready low for the whole stall.
  always @(posedge clk_i) begin
    int unsigned gap;
    if (!rst_ni) begin
      sink_ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      sink_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      gap = pick_gap();
      sink_ready <= (gap == 0);
      stall_left <= (gap == 0) ? 0 : gap - 1;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("No transaction for %0d cycles, %0d results outstanding",
               QuietLimit, pending_cnt);
      $display("[crc_generate_check_serial] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_bit(input logic b, input logic eom);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      src_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    src_valid <= 1'b1;
    src_bit   <= b;
    src_eom   <= eom;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    bits_sent++;
    if (eom) msgs_sent++;
  endtask

  // Drop valid and wait until every result is out, then let the pipeline drain.
  task automatic wait_idle();
    src_valid <= 1'b0;
    do @(posedge clk_i); while (pending_cnt != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(input cfg_reg_e idx, input logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    if (idx == REG_POLY_TERMS) cur_poly = data[PolyW-1:0];
    if (idx == REG_DEGREE) cur_deg = data[DegW-1:0];
  endtask

  task automatic set_config(input logic [PolyW-1:0] poly, input logic [DegW-1:0] deg,
                            input logic chk);
    wait_idle();
    cfg_write(REG_POLY_TERMS, poly);
    cfg_write(REG_DEGREE, CfgDataW'(deg));
    cfg_write(REG_CHECK_MODE, CfgDataW'(chk));
    settings_cnt++;
  endtask

  task automatic send_message(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) send_bit(1'($urandom_range(0, 1)), i == len - 1);
  endtask

  // Message bits followed by their CRC; optionally flip one bit of the codeword.
  task automatic send_codeword(input int unsigned n_msg, input logic corrupt);
    int unsigned d;
    int unsigned flip;
    logic [63:0] mask;
    logic [63:0] r;
    logic        b;
    d    = eff_deg(cur_deg);
    mask = (64'd1 << d) - 64'd1;
    flip = corrupt ? $urandom_range(0, n_msg + d - 1) : n_msg + d;
    r    = '0;
    for (int unsigned i = 0; i < n_msg; i++) begin
      b = 1'($urandom_range(0, 1));
      r = (r[d-1] ^ b) ? (((r << 1) ^ {32'd0, cur_poly}) & mask) : ((r << 1) & mask);
      send_bit(b ^ (i == flip), 1'b0);
    end
    for (int unsigned i = 0; i < d; i++) send_bit(r[d-1-i] ^ (n_msg + i == flip), i == d - 1);
  endtask

  initial begin
    int unsigned sel;
    int unsigned n_msgs;
    logic [DegW-1:0]  deg;
    logic [PolyW-1:0] poly;
    logic             chk;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings, generate mode
    send_bit(1'b1, 1'b0);
    send_bit(1'b0, 1'b0);
    send_bit(1'b1, 1'b1);
    // widest remainder from a single bit
    set_config('1, 6'd32, 1'b0);
    send_bit(1'b1, 1'b1);
    // terms at or above the degree must be dropped
    set_config('1, 6'd1, 1'b0);
    send_bit(1'b0, 1'b0);
    send_bit(1'b1, 1'b1);
    // degree zero behaves as one
    set_config(32'h1, 6'd0, 1'b0);
    send_bit(1'b1, 1'b1);
    // degree above the maximum clamps
    set_config(32'h04C1_1DB7, 6'd63, 1'b0);
    send_bit(1'b1, 1'b0);
    send_bit(1'b1, 1'b1);
    // valid codeword in check mode
    set_config(32'h3, 6'd3, 1'b1);
    send_codeword(1, 1'b0);
    // codeword shorter than the degree
    set_config(32'h7, 6'd8, 1'b1);
    send_bit(1'b1, 1'b0);
    send_bit(1'b0, 1'b1);
    // change degree in the middle of a codeword
    send_bit(1'b1, 1'b0);
    send_bit(1'b1, 1'b0);
    send_bit(1'b0, 1'b0);
    wait_idle();
    cfg_write(REG_DEGREE, CfgDataW'(4));
    send_bit(1'b1, 1'b1);
    // switch degree and mode in the middle of a message
    set_config(32'h9, 6'd5, 1'b0);
    send_bit(1'b1, 1'b0);
    send_bit(1'b0, 1'b0);
    wait_idle();
    cfg_write(REG_DEGREE, CfgDataW'(16));
    cfg_write(REG_CHECK_MODE, CfgDataW'(1));
    send_bit(1'b1, 1'b1);
    // zero polynomial
    set_config('0, 6'd4, 1'b0);
    send_bit(1'b1, 1'b0);
    send_bit(1'b1, 1'b1);

    while (bits_sent < TotalBits) begin
      sel = $urandom_range(0, 99);
      if (sel < 60) deg = DegW'($urandom_range(1, 12));
      else if (sel < 75) deg = DegW'($urandom_range(13, 31));
      else if (sel < 87) deg = 6'd32;
      else if (sel < 93) deg = 6'd0;
      else deg = DegW'($urandom_range(33, 63));
      sel = $urandom_range(0, 9);
      poly = (sel == 0) ? '0 : (sel == 1) ? '1 : PolyW'($urandom());
      chk  = 1'($urandom_range(0, 1));
      set_config(poly, deg, chk);
      no_idle <= ($urandom_range(0, 3) == 0);
      n_msgs = chk ? $urandom_range(4, 8) : $urandom_range(3, 6);
      repeat (n_msgs) begin
        if (bits_sent >= TotalBits) break;
        if (!chk) begin
          send_message(($urandom_range(0, 9) == 0) ? $urandom_range(11, 40)
                                                   : $urandom_range(1, 10));
        end else if ($urandom_range(0, 3) != 0) begin
          send_codeword($urandom_range(1, 8), $urandom_range(0, 3) == 0);
        end else begin
          send_message($urandom_range(1, eff_deg(cur_deg) + 6));
        end
      end
    end

    wait_idle();
    repeat (8) @(posedge clk_i);
    $display("Covered %0d bits in %0d messages over %0d register settings", bits_sent,
             msgs_sent, settings_cnt);
    $display("Compared %0d result transactions, %0d mismatches", result_cnt, fail_cnt);
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("[crc_generate_check_serial] OK");
    end else begin
      $display("[crc_generate_check_serial] ERROR");
    end
    $finish;
  end

endmodule
